[design/pid_speed_duty_regulator_defines.svh]
// Assertion macros shared by the regulator RTL.
`ifndef PID_SPEED_DUTY_REGULATOR_DEFINES_SVH
`define PID_SPEED_DUTY_REGULATOR_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define PSDR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
// Next-cycle implication, disabled during reset.
`define PSDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define PSDR_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define PSDR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[design/psdr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package psdr_pkg;

    localparam int FRAC_BITS = 8;
    localparam int SUM_WIDTH = 24;

    localparam int DATA_W    = 16;
    localparam int ERR_W     = DATA_W + 1;
    localparam int DIFF_W    = DATA_W + 2;
    localparam int MUL_A_W   = DATA_W + 1;
    localparam int MUL_B_W   = (SUM_WIDTH > DIFF_W) ? SUM_WIDTH : DIFF_W;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int CFG_IDX_W = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KP         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KI         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KD         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_CEIL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_START = 3'd5;

    // Register reset values
    localparam logic [DATA_W-1:0] SETPOINT_RST   = 16'd8448;
    localparam logic [DATA_W-1:0] KP_RST         = 16'd51;
    localparam logic [DATA_W-1:0] KI_RST         = 16'd26;
    localparam logic [DATA_W-1:0] KD_RST         = 16'd0;
    localparam logic [DATA_W-1:0] DUTY_CEIL_RST  = 16'd12500;
    localparam logic [DATA_W-1:0] DUTY_START_RST = 16'd6250;

    typedef enum logic [1:0] {
        MSEL_P,
        MSEL_I,
        MSEL_D,
        MSEL_U
    } mul_sel_t;

    typedef struct packed {
        logic     load_err;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_load;
        logic     acc_add;
        logic     ctrl_en;
        logic     duty_en;
    } psdr_cmd_t;

    typedef struct packed {
        logic        [DATA_W-1:0] setpoint;
        logic signed [DATA_W-1:0] kp;
        logic signed [DATA_W-1:0] ki;
        logic signed [DATA_W-1:0] kd;
        logic        [DATA_W-1:0] duty_ceiling;
    } psdr_cfg_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] control_value;
        logic        [DATA_W-1:0] new_duty;
        logic                     saturated;
    } psdr_res_t;

endpackage

`default_nettype wire

[design/psdr_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface psdr_in_if;
    logic                          valid;
    logic                          ready;
    logic [psdr_pkg::DATA_W-1:0]   measured_speed;

    modport source (output valid, output measured_speed, input ready);
    modport sink   (input valid, input measured_speed, output ready);
endinterface

interface psdr_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [psdr_pkg::DATA_W-1:0] control_value;
    logic        [psdr_pkg::DATA_W-1:0] new_duty;
    logic                               saturated;

    modport source (output valid, output control_value, output new_duty, output saturated,
                    input ready);
    modport sink   (input valid, input control_value, input new_duty, input saturated,
                    output ready);
endinterface

`default_nettype wire

[design/psdr_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "pid_speed_duty_regulator_defines.svh"

module psdr_seq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                out_stall,
    output psdr_pkg::psdr_cmd_t      cmd
);
    import psdr_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_MUL_P = 8'b0000_0010,
        ST_MUL_I = 8'b0000_0100,
        ST_MUL_D = 8'b0000_1000,
        ST_ACC   = 8'b0001_0000,
        ST_CTRL  = 8'b0010_0000,
        ST_MUL_U = 8'b0100_0000,
        ST_DUTY  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.mul_sel  = MSEL_P;
        cmd.load_err = accept;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MUL_P;
                end
            end
            ST_MUL_P:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_P;
                state_next  = ST_MUL_I;
            end
            ST_MUL_I:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MSEL_I;
                cmd.acc_load = 1'b1;
                state_next   = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_D;
                cmd.acc_add = 1'b1;
                state_next  = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc_add = 1'b1;
                state_next  = ST_CTRL;
            end
            ST_CTRL:
            begin
                cmd.ctrl_en = 1'b1;
                state_next  = ST_MUL_U;
            end
            ST_MUL_U:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_U;
                state_next  = ST_DUTY;
            end
            ST_DUTY:
            begin
                // hold until the output word slot frees up
                if (!out_stall)
                begin
                    cmd.duty_en = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `PSDR_ASSERT_NEXT(a_accept_starts, clk, rst_n, accept, state_reg == ST_MUL_P)
    `PSDR_ASSERT_IMPLY(a_duty_needs_slot, clk, rst_n, cmd.duty_en, !out_stall)
    `PSDR_ASSERT_IMPLY(a_ready_only_idle, clk, rst_n, in_ready, !cmd.mul_en && !cmd.duty_en)

endmodule

`default_nettype wire

[design/psdr_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module psdr_datapath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire psdr_pkg::psdr_cmd_t         cmd,
    input  wire psdr_pkg::psdr_cfg_t         cfg,
    input  wire logic                        duty_load,
    input  wire logic [psdr_pkg::DATA_W-1:0] duty_load_value,
    input  wire logic [psdr_pkg::DATA_W-1:0] measured_speed,
    output psdr_pkg::psdr_res_t              res
);
    import psdr_pkg::*;

    localparam logic signed [ACC_W-1:0] CTRL_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] CTRL_MIN = -(ACC_W'(32768));

    // Loop state
    logic signed [SUM_WIDTH-1:0] error_sum_reg;
    logic signed [ERR_W-1:0]     last_error_reg;
    logic        [DATA_W-1:0]    duty_now_reg;

    // Per-word working registers
    logic signed [ERR_W-1:0]     err_reg;
    logic signed [DIFF_W-1:0]    diff_reg;
    logic                        isat_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [DATA_W-1:0]    ctrl_reg;
    logic                        csat_reg;

    logic signed [ERR_W-1:0]     err_c;
    logic signed [SUM_WIDTH:0]   sum_wide;
    logic signed [SUM_WIDTH-1:0] sum_c;
    logic                        sum_ovf;
    logic signed [DIFF_W-1:0]    diff_c;

    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]    prod_c;
    logic signed [ACC_W-1:0]     prod_ext;

    logic signed [ACC_W-1:0]     acc_sh;
    logic signed [DATA_W-1:0]    ctrl_c;
    logic                        csat_c;

    logic signed [PROD_W-1:0]    duty_sh;
    logic signed [PROD_W:0]      duty_sum;
    logic signed [PROD_W:0]      max_ext;
    logic        [DATA_W-1:0]    duty_c;
    logic                        dsat_c;

    // Error, saturating integral and difference
    assign err_c    = $signed({1'b0, measured_speed}) - $signed({1'b0, cfg.setpoint});
    assign sum_wide = {error_sum_reg[SUM_WIDTH-1], error_sum_reg}
                    + {{(SUM_WIDTH+1-ERR_W){err_c[ERR_W-1]}}, err_c};
    assign sum_ovf  = sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1];
    assign sum_c    = sum_ovf ? {sum_wide[SUM_WIDTH], {(SUM_WIDTH-1){~sum_wide[SUM_WIDTH]}}}
                              : sum_wide[SUM_WIDTH-1:0];
    assign diff_c   = {err_c[ERR_W-1], err_c} - {last_error_reg[ERR_W-1], last_error_reg};

    // Shared multiplier operand select
    always_comb
    begin
        case (cmd.mul_sel)
            MSEL_P:
            begin
                mul_a = {cfg.kp[DATA_W-1], cfg.kp};
                mul_b = {{(MUL_B_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
            end
            MSEL_I:
            begin
                mul_a = {cfg.ki[DATA_W-1], cfg.ki};
                mul_b = MUL_B_W'(error_sum_reg);
            end
            MSEL_D:
            begin
                mul_a = {cfg.kd[DATA_W-1], cfg.kd};
                mul_b = MUL_B_W'(diff_reg);
            end
            MSEL_U:
            begin
                mul_a = $signed({1'b0, duty_now_reg});
                mul_b = {{(MUL_B_W-DATA_W){ctrl_reg[DATA_W-1]}}, ctrl_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_c   = mul_a * mul_b;
    assign prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    // Scale and saturate the control value
    assign acc_sh = acc_reg >>> FRAC_BITS;
    always_comb
    begin
        if (acc_sh > CTRL_MAX)
        begin
            ctrl_c = 16'sh7FFF;
            csat_c = 1'b1;
        end
        else if (acc_sh < CTRL_MIN)
        begin
            ctrl_c = 16'sh8000;
            csat_c = 1'b1;
        end
        else
        begin
            ctrl_c = acc_sh[DATA_W-1:0];
            csat_c = 1'b0;
        end
    end

    // Multiplicative duty update and clamp
    assign duty_sh  = prod_reg >>> FRAC_BITS;
    assign duty_sum = {duty_sh[PROD_W-1], duty_sh}
                    + $signed({{(PROD_W+1-DATA_W){1'b0}}, duty_now_reg});
    assign max_ext  = $signed({{(PROD_W+1-DATA_W){1'b0}}, cfg.duty_ceiling});

    always_comb
    begin
        if (duty_sum < 0)
        begin
            duty_c = '0;
            dsat_c = 1'b1;
        end
        else if (duty_sum > max_ext)
        begin
            duty_c = cfg.duty_ceiling;
            dsat_c = 1'b1;
        end
        else
        begin
            duty_c = duty_sum[DATA_W-1:0];
            dsat_c = 1'b0;
        end
    end

    assign res.control_value = ctrl_reg;
    assign res.new_duty      = duty_c;
    assign res.saturated     = isat_reg | csat_reg | dsat_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg  <= '0;
            last_error_reg <= '0;
            duty_now_reg   <= DUTY_START_RST;
        end
        else
        begin
            if (cmd.load_err)
            begin
                error_sum_reg  <= sum_c;
                last_error_reg <= err_c;
            end
            if (duty_load)
            begin
                duty_now_reg <= duty_load_value;
            end
            else if (cmd.duty_en)
            begin
                duty_now_reg <= duty_c;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_err)
        begin
            err_reg  <= err_c;
            diff_reg <= diff_c;
            isat_reg <= sum_ovf;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= prod_c;
        end
        if (cmd.acc_load)
        begin
            acc_reg <= prod_ext;
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + prod_ext;
        end
        if (cmd.ctrl_en)
        begin
            ctrl_reg <= ctrl_c;
            csat_reg <= csat_c;
        end
    end

endmodule

`default_nettype wire

[design/pid_speed_duty_regulator.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "pid_speed_duty_regulator_defines.svh"

// Channel  | Dir | Payload                                      | Word
// in_ch    | in  | measured_speed (u16 Q8.8)                    | one speed sample
// out_ch   | out | control_value (s16 Q8.8), new_duty, saturated | one result per sample
// cfg      | in  | cfg_we, cfg_index[2:0], cfg_data[15:0]       | one register write
//
// A sample steps through MUL_P, MUL_I, MUL_D, ACC, CTRL, MUL_U and DUTY before the next may enter:
// one shared 17 x SUM_WIDTH multiplier runs the kp, ki, kd and duty products in turn.
// in_ch.ready is high only while the sequencer is idle; the result register frees the
// sequencer as soon as the word is loaded, so the next sample may enter while it waits.
// A stalled out_ch holds the sequencer in its last step until the result slot is free.
// rst_n clears the loop state at once: integral and last error to zero, duty to 6250.

module pid_speed_duty_regulator (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [psdr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [psdr_pkg::DATA_W-1:0]       cfg_data,
    psdr_in_if.sink                                in_ch,
    psdr_out_if.source                             out_ch
);
    import psdr_pkg::*;

    psdr_cfg_t   cfg_reg;
    psdr_cmd_t   cmd;
    psdr_res_t   res;
    logic        duty_load;
    logic        out_valid_reg;
    logic        out_stall;
    psdr_res_t   out_reg;

    // Register file: write only, one register per edge
    assign duty_load = cfg_we && (cfg_index == REG_DUTY_START);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setpoint     <= SETPOINT_RST;
            cfg_reg.kp           <= KP_RST;
            cfg_reg.ki           <= KI_RST;
            cfg_reg.kd           <= KD_RST;
            cfg_reg.duty_ceiling <= DUTY_CEIL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SETPOINT:   cfg_reg.setpoint     <= cfg_data;
                REG_KP:         cfg_reg.kp           <= cfg_data;
                REG_KI:         cfg_reg.ki           <= cfg_data;
                REG_KD:         cfg_reg.kd           <= cfg_data;
                REG_DUTY_CEIL:  cfg_reg.duty_ceiling <= cfg_data;
                // duty start loads the duty state directly in the datapath
                default:        ;
            endcase
        end
    end

    // Hold the sequencer only while a finished word sits untaken
    assign out_stall = out_valid_reg && !out_ch.ready;

    psdr_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    psdr_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg             (cfg_reg),
        .duty_load       (duty_load),
        .duty_load_value (cfg_data),
        .measured_speed  (in_ch.measured_speed),
        .res             (res)
    );

    // Output word register: load on the last sequencer step, drop on take
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.duty_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.duty_en)
        begin
            out_reg <= res;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.control_value = out_reg.control_value;
    assign out_ch.new_duty      = out_reg.new_duty;
    assign out_ch.saturated     = out_reg.saturated;

    `PSDR_ASSERT_NEXT(a_result_posted, clk, rst_n, cmd.duty_en, out_ch.valid)
    `PSDR_ASSERT_IMPLY(a_no_overwrite, clk, rst_n, cmd.duty_en && out_valid_reg, out_ch.ready)
    `PSDR_ASSERT_IMPLY(a_busy_not_ready, clk, rst_n, cmd.mul_en || cmd.ctrl_en, !in_ch.ready)

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

// Self-checking bench for the PID speed regulator.
//
// A directed script comes first: reset values, exact landings on the duty limits,
// control saturation at both ends, the gain extremes and writes to the two unused
// register indexes. Rows whose result is obvious carry it typed in; the rest go
// through the predictor below.
// Random phases follow: tracking around the setpoint, full-range noise, and two long
// windup runs that drive the integral into its positive and then its negative clamp.
// Registers are only rewritten once every word in flight has come back.
// Both channels draw a random wait per word. Some phases run with no idling at all.
// One phase holds the output off for a long stretch so the block backs up into its
// input.

module tb_top;
    import psdr_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 6;
    localparam int MAX_WAIT       = 17;
    localparam int SETTLE_CYCLES  = 24;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_PHASES     = 18;
    localparam int NUM_ROWS       = 39;

    // Indexes the register file does not decode; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam longint SUM_MAX  = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
    localparam longint SUM_MIN  = -SUM_MAX - 1;
    localparam longint CTRL_MAX = 32767;
    localparam longint CTRL_MIN = -32768;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_SAMPLE,
        ROW_PINNED
    } row_kind_t;

    typedef enum logic [1:0] {
        PH_TRACK,
        PH_NOISE,
        PH_WIND_UP,
        PH_WIND_DOWN
    } phase_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [DATA_W-1:0]     value;
        psdr_res_t             want;
    } script_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [DATA_W-1:0]     cfg_data;

    psdr_in_if  in_ch ();
    psdr_out_if out_ch ();

    pid_speed_duty_regulator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Loop state and register copy of the predictor.
    psdr_cfg_t loop_cfg;
    longint    integ_sum;
    longint    prev_err;
    longint    duty_level;

    psdr_res_t pending_words [$];
    int        mismatches;
    int        quiet_cycles;

    // Typed-in expectation for the next sample word; it replaces the predicted word.
    logic      pin_armed;
    psdr_res_t pin_word;

    // Idle profile, set by the stimulus per phase.
    int        tx_max_gap;
    int        rx_max_stall;
    int        rx_hold_cycles;

    script_row_t bench_script [NUM_ROWS] = '{
        // reset values: zero error leaves the duty alone
        '{ROW_PINNED, '0, 16'd8448, '{16'sd0, 16'd6250, 1'b0}},
        // duty sitting exactly on the duty ceiling is not a clamp
        '{ROW_WRITE, REG_DUTY_CEIL, 16'd6250, '0},
        '{ROW_PINNED, '0, 16'd8448, '{16'sd0, 16'd6250, 1'b0}},
        '{ROW_SAMPLE, '0, 16'h0000, '0},
        '{ROW_SAMPLE, '0, 16'hFFFF, '0},
        // unit proportional gain only
        '{ROW_WRITE, REG_SETPOINT, 16'd16384, '0},
        '{ROW_WRITE, REG_KP, 16'd256, '0},
        '{ROW_WRITE, REG_KI, 16'd0, '0},
        '{ROW_WRITE, REG_KD, 16'd0, '0},
        '{ROW_WRITE, REG_DUTY_CEIL, 16'hFFFF, '0},
        '{ROW_WRITE, REG_DUTY_START, 16'd1000, '0},
        '{ROW_WRITE, REG_SPARE_6, 16'hFFFF, '0},
        '{ROW_WRITE, REG_SPARE_7, 16'hFFFF, '0},
        // control of -1.0 takes the duty exactly to zero, no clamp
        '{ROW_PINNED, '0, 16'd16128, '{-16'sd256, 16'd0, 1'b0}},
        '{ROW_PINNED, '0, 16'd16384, '{16'sd0, 16'd0, 1'b0}},
        // control overflow, positive
        '{ROW_WRITE, REG_SETPOINT, 16'd0, '0},
        '{ROW_WRITE, REG_KP, 16'h7FFF, '0},
        '{ROW_PINNED, '0, 16'hFFFF, '{16'sh7FFF, 16'd0, 1'b1}},
        // control overflow, negative, with the duty driven below zero
        '{ROW_WRITE, REG_KP, 16'h8000, '0},
        '{ROW_WRITE, REG_DUTY_START, 16'd12500, '0},
        '{ROW_WRITE, REG_DUTY_CEIL, 16'd1, '0},
        '{ROW_PINNED, '0, 16'hFFFF, '{16'sh8000, 16'd0, 1'b1}},
        // integral and derivative gain extremes
        '{ROW_WRITE, REG_KP, 16'd0, '0},
        '{ROW_WRITE, REG_KI, 16'h7FFF, '0},
        '{ROW_WRITE, REG_KD, 16'h8000, '0},
        '{ROW_WRITE, REG_DUTY_START, 16'd1, '0},
        '{ROW_SAMPLE, '0, 16'h0000, '0},
        '{ROW_WRITE, REG_KD, 16'h7FFF, '0},
        '{ROW_SAMPLE, '0, 16'hFFFF, '0},
        // full-scale setpoint and duty
        '{ROW_WRITE, REG_SETPOINT, 16'hFFFF, '0},
        '{ROW_WRITE, REG_KP, 16'd1, '0},
        '{ROW_WRITE, REG_KI, 16'hFFFF, '0},
        '{ROW_WRITE, REG_KD, 16'd0, '0},
        '{ROW_WRITE, REG_DUTY_CEIL, 16'hFFFF, '0},
        '{ROW_WRITE, REG_DUTY_START, 16'hFFFF, '0},
        '{ROW_SAMPLE, '0, 16'hFFFF, '0},
        '{ROW_SAMPLE, '0, 16'h0000, '0},
        '{ROW_SAMPLE, '0, 16'h5555, '0},
        '{ROW_SAMPLE, '0, 16'hAAAA, '0}
    };

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Advance the loop state by one speed sample and return the word it should produce.
    // Every scaling shift floors, which >>> on a signed longint does.
    function automatic psdr_res_t regulate_sample(input logic [DATA_W-1:0] speed);
        longint    spd, sp, kp_v, ki_v, kd_v, top;
        longint    err, sum, diff, acc, ctrl, duty;
        logic      sat;
        psdr_res_t word;
        spd  = speed;
        sp   = loop_cfg.setpoint;
        top  = loop_cfg.duty_ceiling;
        kp_v = $signed(loop_cfg.kp);
        ki_v = $signed(loop_cfg.ki);
        kd_v = $signed(loop_cfg.kd);
        sat  = 1'b0;

        err = spd - sp;
        sum = integ_sum + err;
        if (sum > SUM_MAX)
        begin
            sum = SUM_MAX;
            sat = 1'b1;
        end
        if (sum < SUM_MIN)
        begin
            sum = SUM_MIN;
            sat = 1'b1;
        end
        integ_sum = sum;

        diff     = err - prev_err;
        prev_err = err;

        acc  = kp_v * err + ki_v * sum + kd_v * diff;
        ctrl = acc >>> FRAC_BITS;
        if (ctrl > CTRL_MAX)
        begin
            ctrl = CTRL_MAX;
            sat  = 1'b1;
        end
        if (ctrl < CTRL_MIN)
        begin
            ctrl = CTRL_MIN;
            sat  = 1'b1;
        end

        // Multiplicative update, then clamp to 0..duty ceiling.
        duty = duty_level + ((duty_level * ctrl) >>> FRAC_BITS);
        if (duty < 0)
        begin
            duty = 0;
            sat  = 1'b1;
        end
        if (duty > top)
        begin
            duty = top;
            sat  = 1'b1;
        end
        duty_level = duty;

        word.control_value = ctrl[DATA_W-1:0];
        word.new_duty      = duty[DATA_W-1:0];
        word.saturated     = sat;
        return word;
    endfunction

    // Offer one speed word. Change inputs on the falling edge only; hold valid high
    // straight into the next word when no gap is drawn.
    task automatic send_speed(input logic [DATA_W-1:0] speed, input logic pinned,
                              input psdr_res_t want);
        int gap;
        gap = (tx_max_gap > 0) ? $urandom_range(0, tx_max_gap) : 0;
        @(negedge clk);
        pin_armed = pinned;
        pin_word  = want;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.measured_speed <= speed;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    // Drop valid and wait until every predicted word has come back, then let the
    // sequencer settle before anything touches the registers.
    task automatic wait_drained();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Receiver: draw a stall per word; a hold request from the stimulus overrides it.
    initial
    begin : sink_side
        int stall;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = (rx_max_stall > 0) ? $urandom_range(0, rx_max_stall) : 0;
            if (rx_hold_cycles > 0)
            begin
                stall          = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            @(negedge clk);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
        end
    end

    // Monitor: check result words, predict on accepted samples, track register writes.
    always @(posedge clk)
    begin : word_monitor
        psdr_res_t seen;
        psdr_res_t want;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                seen.control_value = out_ch.control_value;
                seen.new_duty      = out_ch.new_duty;
                seen.saturated     = out_ch.saturated;
                if (pending_words.size() == 0)
                begin
                    $error("result word with no sample pending: control_value %0d",
                           seen.control_value);
                    mismatches++;
                end
                else
                begin
                    want = pending_words.pop_front();
                    if (seen.control_value !== want.control_value)
                    begin
                        $error("control_value: expected %0d, got %0d",
                               want.control_value, seen.control_value);
                        mismatches++;
                    end
                    if (seen.new_duty !== want.new_duty)
                    begin
                        $error("new_duty: expected %0d, got %0d",
                               want.new_duty, seen.new_duty);
                        mismatches++;
                    end
                    if (seen.saturated !== want.saturated)
                    begin
                        $error("saturated: expected %0b, got %0b",
                               want.saturated, seen.saturated);
                        mismatches++;
                    end
                end
            end

            if (in_ch.valid && in_ch.ready)
            begin
                want = regulate_sample(in_ch.measured_speed);
                if (pin_armed)
                begin
                    want      = pin_word;
                    pin_armed = 1'b0;
                end
                pending_words.push_back(want);
            end

            // A duty_start write loads the duty at once; spare indexes do nothing.
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SETPOINT:   loop_cfg.setpoint     = cfg_data;
                    REG_KP:         loop_cfg.kp           = cfg_data;
                    REG_KI:         loop_cfg.ki           = cfg_data;
                    REG_KD:         loop_cfg.kd           = cfg_data;
                    REG_DUTY_CEIL:  loop_cfg.duty_ceiling = cfg_data;
                    REG_DUTY_START: duty_level            = cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    // Watchdog: end the run if nothing moves on any port for too long.
    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int                r;
        int                ph;
        int                k;
        int                items;
        int                pick;
        phase_kind_t       kind;
        logic [DATA_W-1:0] setpt;
        logic [DATA_W-1:0] kp_w;
        logic [DATA_W-1:0] ki_w;
        logic [DATA_W-1:0] kd_w;
        logic [DATA_W-1:0] top_w;
        logic [DATA_W-1:0] spd;

        // Drive every input known from time zero and hold reset.
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        in_ch.valid          = 1'b0;
        in_ch.measured_speed = '0;
        pin_armed            = 1'b0;
        pin_word             = '0;
        mismatches           = 0;
        quiet_cycles         = 0;
        rx_hold_cycles       = 0;
        tx_max_gap           = MAX_WAIT;
        rx_max_stall         = MAX_WAIT;

        loop_cfg.setpoint     = SETPOINT_RST;
        loop_cfg.kp           = KP_RST;
        loop_cfg.ki           = KI_RST;
        loop_cfg.kd           = KD_RST;
        loop_cfg.duty_ceiling = DUTY_CEIL_RST;
        integ_sum             = 0;
        prev_err              = 0;
        duty_level            = DUTY_START_RST;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed script.
        for (r = 0; r < NUM_ROWS; r++)
        begin
            case (bench_script[r].kind)
                ROW_WRITE:
                begin
                    wait_drained();
                    write_reg(bench_script[r].idx, bench_script[r].value);
                end
                ROW_PINNED:
                    send_speed(bench_script[r].value, 1'b1, bench_script[r].want);
                default:
                    send_speed(bench_script[r].value, 1'b0, '0);
            endcase
        end

        // Random phases: mixed tracking and noise first, while the integral is small,
        // then push it into the positive clamp and swing it all the way to the negative.
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph == 0)
                kind = PH_TRACK;
            else if (ph == 1)
                kind = PH_NOISE;
            else if (ph < 5)
                kind = ($urandom_range(0, 2) == 0) ? PH_NOISE : PH_TRACK;
            else if (ph < 10)
                kind = PH_WIND_UP;
            else
                kind = PH_WIND_DOWN;

            // Registers change only with the pipe empty; this is also the sender pause.
            wait_drained();

            case (kind)
                PH_TRACK:
                begin
                    setpt = 16'($urandom_range(1024, 64511));
                    kp_w  = 16'(int'($urandom_range(0, 128)) - 64);
                    ki_w  = 16'(int'($urandom_range(0, 8)) - 4);
                    kd_w  = 16'(int'($urandom_range(0, 128)) - 64);
                end
                PH_NOISE:
                begin
                    setpt = 16'($urandom);
                    kp_w  = 16'($urandom);
                    ki_w  = 16'($urandom);
                    kd_w  = 16'($urandom);
                end
                PH_WIND_UP:
                begin
                    setpt = '0;
                    kp_w  = 16'(int'($urandom_range(0, 2)) - 1);
                    ki_w  = '0;
                    kd_w  = 16'(int'($urandom_range(0, 2)) - 1);
                end
                default:
                begin
                    setpt = 16'hFFFF;
                    kp_w  = 16'(int'($urandom_range(0, 2)) - 1);
                    ki_w  = '0;
                    kd_w  = 16'(int'($urandom_range(0, 2)) - 1);
                end
            endcase

            pick = $urandom_range(0, 3);
            if (pick == 0)
                top_w = 16'd1;
            else if (pick == 1)
                top_w = 16'hFFFF;
            else
                top_w = 16'($urandom_range(1, 65535));

            write_reg(REG_SETPOINT, setpt);
            write_reg(REG_KP, kp_w);
            write_reg(REG_KI, ki_w);
            write_reg(REG_KD, kd_w);
            write_reg(REG_DUTY_CEIL, top_w);
            // Mostly start inside the clamp range, sometimes above it.
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_DUTY_START, 16'($urandom_range(0, top_w)));
            else
                write_reg(REG_DUTY_START, 16'($urandom));
            if ($urandom_range(0, 3) == 0)
                write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_7 : REG_SPARE_6,
                          16'($urandom));

            // Idle profile: a clean stretch, a fully idling one, then random mixes.
            if (ph == 0)
            begin
                tx_max_gap   = 0;
                rx_max_stall = 0;
            end
            else if (ph == 1)
            begin
                tx_max_gap   = MAX_WAIT;
                rx_max_stall = MAX_WAIT;
            end
            else
            begin
                tx_max_gap   = ($urandom_range(0, 1) == 1) ? MAX_WAIT : 0;
                rx_max_stall = ($urandom_range(0, 1) == 1) ? MAX_WAIT : 0;
            end

            // Back up the block: hold the output off while samples keep coming.
            if (ph == 2)
            begin
                rx_hold_cycles = LONG_HOLD;
                tx_max_gap     = 0;
            end

            items = (kind == PH_WIND_UP || kind == PH_WIND_DOWN) ? 36 : $urandom_range(10, 30);
            for (k = 0; k < items; k++)
            begin
                case (kind)
                    PH_TRACK:
                        spd = 16'(int'(setpt) + int'($urandom_range(0, 1023)) - 512);
                    PH_NOISE:
                        spd = 16'($urandom);
                    PH_WIND_UP:
                        spd = 16'($urandom_range(60000, 65535));
                    default:
                        spd = 16'($urandom_range(0, 2047));
                endcase
                send_speed(spd, 1'b0, '0);
            end
        end

        wait_drained();

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
